// File: design/assert_macros.svh
// assertion macros used by the encoder top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: design/lz78_pkg.sv
// shared types and constants for the lz78 phrase encoder
package lz78_pkg;

  localparam int IDX_W  = 13;
  localparam int BYTE_W = 8;
  // scan base holds a slot number plus one row step
  localparam int BASE_W = IDX_W + 1;

  localparam int DEF_MAX_ENTRIES = 4096;
  localparam int DEF_CELLS       = 16;

  localparam logic [IDX_W-1:0] CFG_MAX_RESET = 13'd4096;

  localparam logic KIND_PAIR  = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  localparam int OUT_FIELDS_W = BYTE_W + 2 * IDX_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // one dictionary entry, also the search key
  typedef struct packed {
    logic [IDX_W-1:0]  parent;
    logic [BYTE_W-1:0] sym;
  } key_t;

  // search token handed from cell to cell, one per row of the banks
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [BASE_W-1:0] base;
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
  } chain_tok_t;

endpackage

// File: design/lz78_ram.sv
// generic simple dual-port ram with registered read
module lz78_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/lz78_cell.sv
// one cell of the search chain: a dictionary bank and a compare stage
module lz78_cell #(
  parameter int MAX_ENTRIES = 4096,
  parameter int CELLS       = 16,
  parameter int CELL_ID     = 0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lz78_pkg::chain_tok_t                tok_in,
  output lz78_pkg::chain_tok_t                tok_out,
  input  lz78_pkg::key_t                      key,
  input  logic [lz78_pkg::IDX_W-1:0]          total,
  input  logic                                wr_en,
  input  logic [$clog2(CELLS)-1:0]            wr_bank,
  input  logic [((MAX_ENTRIES + CELLS - 1) / CELLS > 1 ?
                 $clog2((MAX_ENTRIES + CELLS - 1) / CELLS) : 1)-1:0] wr_row,
  input  lz78_pkg::key_t                      wr_key
);
  import lz78_pkg::*;

  localparam int CELL_W     = $clog2(CELLS);
  localparam int BANK_DEPTH = (MAX_ENTRIES + CELLS - 1) / CELLS;
  localparam int ROW_W      = BANK_DEPTH > 1 ? $clog2(BANK_DEPTH) : 1;
  localparam int SLOT_W     = ROW_W + CELL_W;

  chain_tok_t        tok_q;
  key_t              rd_key;
  logic [SLOT_W-1:0] rd_slot;
  logic [BASE_W-1:0] slot;
  logic [BASE_W-1:0] slot_plus;
  logic              bank_we;
  logic              found;

  // the bank is read with the incoming row so data lines up with tok_q
  assign rd_slot = SLOT_W'(tok_in.base);
  assign bank_we = wr_en && (wr_bank == CELL_W'(CELL_ID));

  lz78_ram #(
    .WIDTH ($bits(key_t)),
    .DEPTH (BANK_DEPTH)
  ) u_bank (
    .clk   (clk),
    .we    (bank_we),
    .waddr (wr_row),
    .wdata (wr_key),
    .raddr (rd_slot[SLOT_W-1:CELL_W]),
    .rdata (rd_key)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_in;
    end
  end

  assign slot      = tok_q.base + BASE_W'(CELL_ID);
  assign slot_plus = slot + BASE_W'(1);
  // slots at or past the fill count hold no current entry
  assign found = tok_q.valid && (slot < {1'b0, total}) && (rd_key == key);

  always_comb begin
    tok_out = tok_q;
    if (found) begin
      tok_out.hit     = 1'b1;
      tok_out.hit_idx = slot_plus[IDX_W-1:0];
    end
  end

endmodule

// File: design/lz78_phrase_encoder_top.sv
// LZ78 phrase encoder: control, output register and the chain of search cells
//
// Bytes enter on the s_axis side, one at a time; a byte that does not extend the current
// phrase produces one token on the m_axis side, a byte that does produces nothing unless it
// ends the stream. The dictionary is split round-robin over CELLS banks, one per cell, and a
// search token per bank row runs down the cell chain; the time per byte is set by the row scan
// and the pass along the chain while entries are in the dictionary, and an empty dictionary
// skips the search. A byte is accepted only between searches, while a finished token may still
// sit in the output register. The user writes max_entries through cfg_wr_en and cfg_wr_data
// only while the block is idle; the block itself does not enforce this.
`include "assert_macros.svh"

module lz78_phrase_encoder_top #(
  parameter int MAX_ENTRIES = lz78_pkg::DEF_MAX_ENTRIES,  // 1 to 8191
  parameter int CELLS       = lz78_pkg::DEF_CELLS         // power of two, 2 to 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [lz78_pkg::BYTE_W-1:0]       s_axis_tdata,   // data_byte
  input  logic                              s_axis_tlast,   // last_byte
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // symbol, phrase_index, entries_used, zero padding
  output logic [lz78_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tuser,   // token_kind
  output logic                              m_axis_tlast,   // stream_end
  input  logic                              cfg_wr_en,
  input  logic [lz78_pkg::IDX_W-1:0]        cfg_wr_data     // max_entries
);
  import lz78_pkg::*;

  localparam int CELL_W     = $clog2(CELLS);
  localparam int BANK_DEPTH = (MAX_ENTRIES + CELLS - 1) / CELLS;
  localparam int ROW_W      = BANK_DEPTH > 1 ? $clog2(BANK_DEPTH) : 1;
  localparam int SLOT_W     = ROW_W + CELL_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } state_t;

  state_t            state;
  logic [IDX_W-1:0]  max_entries;
  logic [IDX_W-1:0]  entry_total;
  logic [IDX_W-1:0]  match_index;
  key_t              key;
  logic              last_q;
  logic [BASE_W-1:0] scan_base;
  logic              hit_q;
  logic [IDX_W-1:0]  hit_idx_q;

  logic              out_valid;
  logic              out_kind;
  logic [BYTE_W-1:0] out_symbol;
  logic [IDX_W-1:0]  out_index;
  logic [IDX_W-1:0]  out_used;
  logic              out_end;

  chain_tok_t        tok [CELLS+1];
  chain_tok_t        tok_end;
  logic [BASE_W-1:0] scan_next;
  logic              room;
  logic              emit;
  logic              out_free;
  logic              go;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_slot;
  logic [IDX_W-1:0]  total_grown;

  assign scan_next = scan_base + BASE_W'(CELLS);

  always_comb begin
    tok[0]         = '0;
    tok[0].valid   = (state == ST_SCAN);
    tok[0].last    = (scan_next >= {1'b0, entry_total});
    tok[0].base    = scan_base;
  end

  assign wr_slot = SLOT_W'(entry_total);

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    lz78_cell #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .CELLS       (CELLS),
      .CELL_ID     (k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[k]),
      .tok_out (tok[k+1]),
      .key     (key),
      .total   (entry_total),
      .wr_en   (wr_en),
      .wr_bank (wr_slot[CELL_W-1:0]),
      .wr_row  (wr_slot[SLOT_W-1:CELL_W]),
      .wr_key  (key)
    );
  end

  assign tok_end = tok[CELLS];

  // room while below both the written limit and the store size
  assign room        = (entry_total < max_entries) && (32'(entry_total) < MAX_ENTRIES);
  assign total_grown = entry_total + IDX_W'(room);
  assign emit        = (state == ST_DECIDE) && (!hit_q || last_q);
  assign out_free    = !out_valid || m_axis_tready;
  assign go          = (state == ST_DECIDE) && (!emit || out_free);
  assign wr_en       = go && !hit_q && room;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      max_entries <= CFG_MAX_RESET;
      entry_total <= '0;
      match_index <= '0;
      hit_q       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_entries <= cfg_wr_data;
      end
      // a new token replaces the one leaving in the same transfer
      if (go && emit) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      // a hit may come out of the chain while later rows are still issued
      if (tok_end.valid && tok_end.hit) begin
        hit_q     <= 1'b1;
        hit_idx_q <= tok_end.hit_idx;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            key.parent <= match_index;
            key.sym    <= s_axis_tdata;
            last_q     <= s_axis_tlast;
            scan_base  <= '0;
            hit_q      <= 1'b0;
            state      <= (entry_total == '0) ? ST_DECIDE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          scan_base <= scan_next;
          if (tok[0].last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (tok_end.valid && tok_end.last) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (go) begin
            state <= ST_IDLE;
            if (hit_q && !last_q) begin
              match_index <= hit_idx_q;
            end else if (hit_q) begin
              out_kind    <= KIND_FINAL;
              out_symbol  <= '0;
              out_index   <= hit_idx_q;
              out_used    <= entry_total;
              out_end     <= 1'b1;
              entry_total <= '0;
              match_index <= '0;
            end else begin
              out_kind    <= KIND_PAIR;
              out_symbol  <= key.sym;
              out_index   <= key.parent;
              out_used    <= total_grown;
              out_end     <= last_q;
              entry_total <= last_q ? '0 : total_grown;
              match_index <= '0;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_DATA_W - OUT_FIELDS_W)'(0), out_used, out_index, out_symbol};
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_end;

  `ASSERT_IMPL(a_total_cap, clk, rst, 1'b1, 32'(entry_total) <= MAX_ENTRIES)
  `ASSERT_IMPL(a_final_nonzero, clk, rst, out_valid && out_kind == KIND_FINAL, out_index != '0)
  `ASSERT_IMPL(a_index_le_used, clk, rst, out_valid, out_index <= out_used)
  `ASSERT_IMPL(a_chain_empty_idle, clk, rst, state == ST_IDLE, !tok_end.valid)

endmodule
